// ===== rtl/core/b64d_pkg.sv =====
// Package for the base64 stream decoder: word structs, CSR indexes,
// character codes and the alphabet lookup. No dependencies.
package b64d_pkg;

   // Input word: one character and its end-of-message mark
   typedef struct packed {
      logic [7:0] in_char;
      logic       is_last;
   } req_word_type;

   // Output word: one decoded byte
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        run_last;
      logic [15:0] byte_count;
   } rsp_word_type;

   // CSR register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_URL_ALPHABET = 1'b0,
      CSR_MAX_OUTPUT   = 1'b1
   } csr_index_type;

   // Position of the next character within its group of four
   typedef enum logic [1:0] {
      SLOT_0 = 2'd0,
      SLOT_1 = 2'd1,
      SLOT_2 = 2'd2,
      SLOT_3 = 2'd3
   } slot_type;

   // Output queue geometry
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = 3;
   localparam int FIFO_CNT_BITS = 4;
   localparam int MAX_PUSH      = 3;

   // Character codes
   localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
   localparam logic [7:0] CHAR_DASH  = 8'h2D; // '-'
   localparam logic [7:0] CHAR_UNDER = 8'h5F; // '_'
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_DIG_0 = 8'h30;
   localparam logic [7:0] CHAR_DIG_9 = 8'h39;

   localparam logic [6:0] VAL_LC_BASE  = 7'd26;
   localparam logic [6:0] VAL_DIG_BASE = 7'd52;
   localparam logic [6:0] VAL_62       = 7'd62;
   localparam logic [6:0] VAL_63       = 7'd63;
   localparam logic [6:0] VAL_UNKNOWN  = 7'd64;

   // Map one character to its 6-bit value; anything else gives 64
   function automatic logic [6:0] char_value(input logic [7:0] c, input logic url);
      logic [7:0] c62;
      logic [7:0] c63;
      logic [7:0] diff;
      c62  = url ? CHAR_DASH : CHAR_PLUS;
      c63  = url ? CHAR_UNDER : CHAR_SLASH;
      diff = 8'd0;
      priority if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         diff = c - CHAR_UC_A;
         return diff[6:0];
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         diff = c - CHAR_LC_A;
         return diff[6:0] + VAL_LC_BASE;
      end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
         diff = c - CHAR_DIG_0;
         return diff[6:0] + VAL_DIG_BASE;
      end else if (c == c62) begin
         return VAL_62;
      end else if (c == c63) begin
         return VAL_63;
      end else begin
         return VAL_UNKNOWN;
      end
   endfunction

endpackage

// ===== rtl/core/base64_stream_decoder_core.sv =====
// Base64 stream decoder top level: input register, group decode and
// output byte queue. Depends on b64d_pkg.
//
// Takes one base64 character per req word and returns decoded bytes, one per
// rsp word. A character is taken every cycle as long as the output queue has
// room for three more bytes; decode happens while a character sits in the
// input register and the queue has that room, writing its bytes into the
// output queue. Results drain at one byte per cycle, so with rsp never stalled
// the sustained rate is one character per cycle (a full group of four gives
// three bytes). The eight-entry byte queue sets how long rsp may stall before
// req stalls. The user is to write url_alphabet and max_output through the csr
// port only while the block is idle, unchecked by it; csr_ready is always high.
module base64_stream_decoder_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Character input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  b64d_pkg::req_word_type               req_word,
   // Byte output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output b64d_pkg::rsp_word_type               rsp_word,
   // Configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [b64d_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [b64d_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   // Width for count sums and the limit compare
   localparam int SW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
   localparam logic [SW-1:0] COUNT_CAP = SW'((64'd1 << COUNT_BITS) - 64'd1);

   // Configuration registers
   logic        url_alphabet_ff;
   logic [15:0] max_output_ff;

   // Input register
   logic                   in_valid_ff, in_valid_in;
   b64d_pkg::req_word_type in_word_ff;

   // Decoder state
   b64d_pkg::slot_type     group_pos_ff, group_pos_in;
   logic [6:0]             held0_ff, held0_in;
   logic [6:0]             held1_ff, held1_in;
   logic [6:0]             held2_ff, held2_in;
   logic                   third_pad_ff, third_pad_in;
   logic [COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic                   halted_ff, halted_in;

   // Output queue
   b64d_pkg::rsp_word_type                fifo_mem [b64d_pkg::FIFO_DEPTH];
   logic [b64d_pkg::FIFO_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::FIFO_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::FIFO_CNT_BITS-1:0]    fifo_cnt_ff, fifo_cnt_in;

   logic                   fire;
   logic                   req_take;
   logic                   rsp_take;
   logic [1:0]             push_n;
   b64d_pkg::rsp_word_type push_word [b64d_pkg::MAX_PUSH];

   // Handshakes
   assign fire      = in_valid_ff &&
                      (fifo_cnt_ff <= b64d_pkg::FIFO_CNT_BITS'(b64d_pkg::FIFO_DEPTH
                                                               - b64d_pkg::MAX_PUSH));
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (fifo_cnt_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_word  = fifo_mem[rd_ptr_ff];
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
         max_output_ff   <= 16'hFFFF;
      end else if (csr_valid && csr_ready) begin
         unique case (b64d_pkg::csr_index_type'(csr_index))
            b64d_pkg::CSR_URL_ALPHABET: url_alphabet_ff <= csr_data[0];
            b64d_pkg::CSR_MAX_OUTPUT:   max_output_ff   <= csr_data[15:0];
         endcase
      end
   end

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_word_ff <= req_word;
      end
   end

   // Group decode: next state and up to three bytes
   always_comb begin
      logic [6:0]        v;
      logic              pad;
      logic              emit;
      logic [1:0]        nb;
      logic [6:0]        v3;
      logic [6:0]        h1;
      logic [6:0]        h2;
      logic [31:0]       word;
      logic [SW-1:0]     limit;
      logic [SW-1:0]     cnt_ext;
      logic [SW-1:0]     sum;
      logic [SW-1:0]     bc;
      logic [7:0]        bytes [3];

      v       = b64d_pkg::char_value(in_word_ff.in_char, url_alphabet_ff);
      pad     = (in_word_ff.in_char == b64d_pkg::CHAR_PAD);
      emit    = 1'b0;
      nb      = 2'd0;
      v3      = 7'd0;
      h1      = held1_ff;
      h2      = held2_ff;
      push_n  = 2'd0;

      group_pos_in = group_pos_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      held2_in     = held2_ff;
      third_pad_in = third_pad_ff;
      out_count_in = out_count_ff;
      halted_in    = halted_ff;

      if (fire && !halted_ff) begin
         unique case (group_pos_ff)
            b64d_pkg::SLOT_0: begin
               held0_in     = v;
               group_pos_in = b64d_pkg::SLOT_1;
            end
            b64d_pkg::SLOT_1: begin
               held1_in     = v;
               h1           = v;
               group_pos_in = b64d_pkg::SLOT_2;
               if (in_word_ff.is_last) begin
                  emit      = 1'b1;
                  nb        = 2'd1;
                  halted_in = 1'b1;
               end
            end
            b64d_pkg::SLOT_2: begin
               third_pad_in = pad;
               held2_in     = v;
               h2           = v;
               group_pos_in = b64d_pkg::SLOT_3;
               if (in_word_ff.is_last) begin
                  emit      = 1'b1;
                  nb        = pad ? 2'd1 : 2'd2;
                  halted_in = 1'b1;
               end
            end
            b64d_pkg::SLOT_3: begin
               emit         = 1'b1;
               nb           = third_pad_ff ? 2'd1 : (pad ? 2'd2 : 2'd3);
               v3           = pad ? 7'd0 : v;
               if (third_pad_ff || pad) begin
                  halted_in = 1'b1;
               end
               group_pos_in = b64d_pkg::SLOT_0;
               third_pad_in = 1'b0;
            end
         endcase
      end

      // Byte limit check
      limit   = (SW'(max_output_ff) < COUNT_CAP) ? SW'(max_output_ff) : COUNT_CAP;
      cnt_ext = SW'(out_count_ff);
      sum     = cnt_ext + SW'(nb);
      if (emit) begin
         if (sum > limit) begin
            halted_in = 1'b1;
         end else begin
            push_n       = nb;
            out_count_in = out_count_ff + COUNT_BITS'(nb);
         end
      end

      // Assemble the 24-bit group; bit 6 of an unknown value spills upward
      word = (32'(held0_ff) << 18) | (32'(h1) << 12);
      if (nb >= 2'd2) word = word | (32'(h2) << 6);
      if (nb >= 2'd3) word = word | 32'(v3);
      bytes[0] = word[23:16];
      bytes[1] = word[15:8];
      bytes[2] = word[7:0];

      for (int k = 0; k < b64d_pkg::MAX_PUSH; k++) begin
         bc = cnt_ext + SW'(k + 1);
         push_word[k].out_byte   = bytes[k];
         push_word[k].run_last   = (2'(k + 1) == nb);
         push_word[k].byte_count = bc[15:0];
      end

      // Message end clears the group, the count and the halt
      if (fire && in_word_ff.is_last) begin
         group_pos_in = b64d_pkg::SLOT_0;
         third_pad_in = 1'b0;
         out_count_in = '0;
         halted_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= b64d_pkg::SLOT_0;
         third_pad_ff <= 1'b0;
         out_count_ff <= '0;
         halted_ff    <= 1'b0;
      end else begin
         group_pos_ff <= group_pos_in;
         third_pad_ff <= third_pad_in;
         out_count_ff <= out_count_in;
         halted_ff    <= halted_in;
      end
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      held2_ff <= held2_in;
   end

   // Output queue pointers
   always_comb begin
      wr_ptr_in   = wr_ptr_ff + b64d_pkg::FIFO_PTR_BITS'(push_n);
      rd_ptr_in   = rd_ptr_ff + b64d_pkg::FIFO_PTR_BITS'(rsp_take);
      fifo_cnt_in = fifo_cnt_ff + b64d_pkg::FIFO_CNT_BITS'(push_n)
                    - b64d_pkg::FIFO_CNT_BITS'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   // Queue storage: up to three consecutive entries written per cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < b64d_pkg::MAX_PUSH; k++) begin
         if (2'(k) < push_n) begin
            fifo_mem[wr_ptr_ff + b64d_pkg::FIFO_PTR_BITS'(k)] <= push_word[k];
         end
      end
   end

endmodule

// ===== rtl/core/b64d_checker.sv =====
// Port-level checks for the base64 stream decoder, with the bind that
// attaches them to base64_stream_decoder_core. Depends on b64d_pkg.
module b64d_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input b64d_pkg::rsp_word_type rsp_word
);

   // Last rsp word taken, to follow the count within a group
   logic        prev_valid_ff;
   logic        prev_last_ff;
   logic [15:0] prev_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         prev_valid_ff <= 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
         prev_last_ff  <= rsp_word.run_last;
         prev_count_ff <= rsp_word.byte_count;
      end
   end

   // A stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // Every byte carries a count of at least one
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.byte_count != 16'd0)
      else $error("rsp byte_count is zero");

   // Bytes of one group count up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && prev_valid_ff && !prev_last_ff
      |-> rsp_word.byte_count == prev_count_ff + 16'd1)
      else $error("rsp byte_count skipped within a group");

   // Queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
